// ----- hw/rtl/obpoc_pkg.sv -----
package obpoc_pkg;

    localparam int QTY_BITS = 32;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // Control from the sequencer to one side table.
    typedef struct packed {
        logic clear;     // clearing pass: invalidate the entry at the address
        logic start;     // new update: restart lookup and best tracking
        logic rd_en;     // read the entry at the address
        logic match_en;  // this side is the side of the current update
        logic commit;    // apply the update to the table
        logic qty_zero;  // the update deletes its level
    } t_side_ctl;

    // Status from one side table, valid once the scan has drained.
    typedef struct packed {
        logic have;      // side holds a level after the update
        logic full;      // insert found no free entry
    } t_side_sts;

endpackage

// ----- hw/rtl/obpoc_side.sv -----
module obpoc_side #(
    parameter int DEPTH      = 64,
    parameter int PRICE_BITS = 32,
    parameter bit WANT_MAX   = 1'b1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  obpoc_pkg::t_side_ctl                i_ctl,
    input  logic [$clog2(DEPTH)-1:0]            i_addr,
    input  logic [PRICE_BITS-1:0]               i_price,
    input  logic [obpoc_pkg::QTY_BITS-1:0]      i_qty,
    output obpoc_pkg::t_side_sts                o_sts,
    output logic [PRICE_BITS-1:0]               o_best
);

    localparam int IW = $clog2(DEPTH);

    // Each word holds a valid flag above the price.
    logic [PRICE_BITS:0]               r_mem  [DEPTH];
    logic [obpoc_pkg::QTY_BITS-1:0]    r_qmem [DEPTH];

    logic [PRICE_BITS:0]    r_word;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_idx;

    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_free;
    logic [IW-1:0]          r_free_idx;
    logic                   r_any;
    logic [PRICE_BITS-1:0]  r_best;

    logic                   rd_valid_bit;
    logic [PRICE_BITS-1:0]  rd_price;
    logic                   rd_match;
    logic                   take_hit;
    logic                   take_free;
    logic                   take_best;
    logic                   add_level;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [PRICE_BITS:0]    wr_word;
    logic                   qwr_en;
    logic [IW-1:0]          qwr_addr;

    function automatic logic better(input logic [PRICE_BITS-1:0] a,
                                    input logic [PRICE_BITS-1:0] b);
        if (WANT_MAX) begin
            return $signed(a) > $signed(b);
        end else begin
            return $signed(a) < $signed(b);
        end
    endfunction

    assign rd_valid_bit = r_word[PRICE_BITS];
    assign rd_price     = r_word[PRICE_BITS-1:0];
    assign rd_match     = i_ctl.match_en && (rd_price == i_price);

    assign take_hit  = r_rd_vld && rd_valid_bit && rd_match && !r_hit;
    assign take_free = r_rd_vld && !rd_valid_bit && !r_free;
    // The level being updated is left out of the fold and added back below
    // when it survives the update, so a delete drops it from the best.
    assign take_best = r_rd_vld && rd_valid_bit && !rd_match &&
                       (!r_any || better(rd_price, r_best));

    assign add_level = i_ctl.match_en && !i_ctl.qty_zero && (r_hit || r_free);

    always_comb begin
        o_sts.have = r_any || add_level;
        o_sts.full = i_ctl.match_en && !i_ctl.qty_zero && !r_hit && !r_free;
        if (add_level && (!r_any || better(i_price, r_best))) begin
            o_best = i_price;
        end else begin
            o_best = r_best;
        end
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = i_addr;
        wr_word  = {1'b0, i_price};
        qwr_en   = 1'b0;
        qwr_addr = r_hit_idx;
        if (i_ctl.clear) begin
            wr_en = 1'b1;
        end else if (i_ctl.commit && i_ctl.match_en) begin
            if (i_ctl.qty_zero) begin
                wr_en   = r_hit;
                wr_addr = r_hit_idx;
            end else if (r_hit) begin
                qwr_en = 1'b1;
            end else if (r_free) begin
                wr_en    = 1'b1;
                wr_addr  = r_free_idx;
                wr_word  = {1'b1, i_price};
                qwr_en   = 1'b1;
                qwr_addr = r_free_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (qwr_en) begin
            r_qmem[qwr_addr] <= i_qty;
        end
        if (i_ctl.rd_en) begin
            r_word <= r_mem[i_addr];
        end
        r_rd_idx <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.rd_en;
            if (i_ctl.start) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_any  <= 1'b0;
            end else begin
                if (take_hit) begin
                    r_hit <= 1'b1;
                end
                if (take_free) begin
                    r_free <= 1'b1;
                end
                if (take_best) begin
                    r_any <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (take_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (take_best) begin
            r_best <= rd_price;
        end
    end

endmodule

// ----- hw/rtl/order_book_best_price_offset_coder.sv -----
// Price-level table for one order book with explicit-mode price coding. Each
// update transfer is looked up in its side's table by a scan that reads one
// entry per cycle from a synchronous memory. An item passes through the reads
// of all SIDE_DEPTH entries, a drain of the last read into the lookup state, a
// write-back and an idle state before the next item is accepted. A write-back
// also waits while the previous result is still waiting for its transfer. The
// scan of both sides runs together and also folds the best bid and best ask,
// which are loaded at the end of a batch. After reset a clearing pass over all
// SIDE_DEPTH entries invalidates both tables; no update is accepted until it
// ends. The result of an item is held in an output register until its
// transfer; the best-price outputs show the state after the last item of the
// latest completed batch.
module order_book_best_price_offset_coder #(
    parameter int SIDE_DEPTH = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_side,
    input  logic [PRICE_BITS-1:0]             i_price_ticks,
    input  logic [obpoc_pkg::QTY_BITS-1:0]    i_quantity,
    input  logic                              i_batch_end,

    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [PRICE_BITS+1:0]             o_price_code,
    output logic                              o_price_is_absolute,
    output logic                              o_is_delete,
    output logic                              o_table_full,
    output logic                              o_have_bid,
    output logic [PRICE_BITS-1:0]             o_best_bid,
    output logic                              o_have_ask,
    output logic [PRICE_BITS-1:0]             o_best_ask
);

    localparam int IW = $clog2(SIDE_DEPTH);
    localparam int CW = PRICE_BITS + 2;
    localparam logic [IW-1:0] LAST_IDX = IW'(SIDE_DEPTH - 1);
    localparam logic [IW:0]   SCAN_END = (IW + 1)'(SIDE_DEPTH);

    obpoc_pkg::t_state r_state, n_state;
    logic [IW:0]                        r_idx, n_idx;
    logic                               r_rd_pend;

    logic                               r_side;
    logic [PRICE_BITS-1:0]              r_price;
    logic [obpoc_pkg::QTY_BITS-1:0]     r_qty;
    logic                               r_last;

    logic                               r_have_bid;
    logic [PRICE_BITS-1:0]              r_best_bid;
    logic                               r_have_ask;
    logic [PRICE_BITS-1:0]              r_best_ask;

    logic                               r_out_valid;
    logic [CW-1:0]                      r_out_code;
    logic                               r_out_abs;
    logic                               r_out_del;
    logic                               r_out_full;

    logic                               accept;
    logic                               out_free;
    logic                               rd_en;
    logic                               commit;
    logic                               qty_zero;

    obpoc_pkg::t_side_ctl               bid_ctl;
    obpoc_pkg::t_side_ctl               ask_ctl;
    obpoc_pkg::t_side_sts               bid_sts;
    obpoc_pkg::t_side_sts               ask_sts;
    logic [PRICE_BITS-1:0]              bid_best;
    logic [PRICE_BITS-1:0]              ask_best;

    logic                               have_s;
    logic [PRICE_BITS-1:0]              best_s;
    logic [PRICE_BITS:0]                px;
    logic [PRICE_BITS:0]                bx;
    logic [PRICE_BITS:0]                diff;
    logic [CW-1:0]                      code;

    assign out_free = !r_out_valid || i_ready;
    assign accept   = i_valid && (r_state == obpoc_pkg::ST_IDLE);
    assign rd_en    = (r_state == obpoc_pkg::ST_SCAN) && (r_idx < SCAN_END);
    assign commit   = (r_state == obpoc_pkg::ST_WRITE) && out_free;
    assign qty_zero = (r_qty == '0);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            obpoc_pkg::ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx[IW-1:0] == LAST_IDX) begin
                    n_state = obpoc_pkg::ST_IDLE;
                end
            end
            obpoc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = obpoc_pkg::ST_SCAN;
                    n_idx   = '0;
                end
            end
            obpoc_pkg::ST_SCAN: begin
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = obpoc_pkg::ST_WRITE;
                end
            end
            obpoc_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = obpoc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = obpoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= obpoc_pkg::ST_CLEAR;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_pend <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_side  <= i_side;
            r_price <= i_price_ticks;
            r_qty   <= i_quantity;
            r_last  <= i_batch_end;
        end
    end

    always_comb begin
        bid_ctl.clear    = (r_state == obpoc_pkg::ST_CLEAR);
        bid_ctl.start    = accept;
        bid_ctl.rd_en    = rd_en;
        bid_ctl.match_en = (r_side == obpoc_pkg::SIDE_BID);
        bid_ctl.commit   = commit;
        bid_ctl.qty_zero = qty_zero;
        ask_ctl          = bid_ctl;
        ask_ctl.match_en = (r_side == obpoc_pkg::SIDE_ASK);
    end

    obpoc_side #(
        .DEPTH      (SIDE_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .WANT_MAX   (1'b1)
    ) u_bid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (bid_ctl),
        .i_addr  (r_idx[IW-1:0]),
        .i_price (r_price),
        .i_qty   (r_qty),
        .o_sts   (bid_sts),
        .o_best  (bid_best)
    );

    obpoc_side #(
        .DEPTH      (SIDE_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .WANT_MAX   (1'b0)
    ) u_ask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ask_ctl),
        .i_addr  (r_idx[IW-1:0]),
        .i_price (r_price),
        .i_qty   (r_qty),
        .o_sts   (ask_sts),
        .o_best  (ask_best)
    );

    // The code uses the best prices held before this item's batch recompute.
    always_comb begin
        have_s = (r_side == obpoc_pkg::SIDE_ASK) ? r_have_ask : r_have_bid;
        best_s = (r_side == obpoc_pkg::SIDE_ASK) ? r_best_ask : r_best_bid;
        px     = {r_price[PRICE_BITS-1], r_price};
        bx     = {best_s[PRICE_BITS-1], best_s};
        if (!have_s) begin
            diff = px;
        end else if (r_side == obpoc_pkg::SIDE_ASK) begin
            diff = px - bx;
        end else begin
            diff = bx - px;
        end
        code = {diff, 1'b0} ^ {CW{diff[PRICE_BITS]}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have_bid  <= 1'b0;
            r_best_bid  <= '0;
            r_have_ask  <= 1'b0;
            r_best_ask  <= '0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit && r_last) begin
                r_have_bid <= bid_sts.have;
                r_have_ask <= ask_sts.have;
                if (bid_sts.have) begin
                    r_best_bid <= bid_best;
                end
                if (ask_sts.have) begin
                    r_best_ask <= ask_best;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_code <= code;
            r_out_abs  <= !have_s;
            r_out_del  <= qty_zero;
            r_out_full <= bid_sts.full || ask_sts.full;
        end
    end

    assign o_ready             = (r_state == obpoc_pkg::ST_IDLE);
    assign o_valid             = r_out_valid;
    assign o_price_code        = r_out_code;
    assign o_price_is_absolute = r_out_abs;
    assign o_is_delete         = r_out_del;
    assign o_table_full        = r_out_full;
    assign o_have_bid          = r_have_bid;
    assign o_best_bid          = r_best_bid;
    assign o_have_ask          = r_have_ask;
    assign o_best_ask          = r_best_ask;

    a_full_not_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_table_full && o_is_delete))
        else $error("table full flagged on a delete");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_valid)
        else $error("finished item did not produce a result");

    a_best_only_at_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_best_bid != $past(r_best_bid)))
            |-> $past(commit && r_last))
        else $error("best bid changed outside a batch end");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == obpoc_pkg::ST_SCAN) |-> !o_ready)
        else $error("update accepted during a table scan");

endmodule
